// ----- src/gwm_pkg.sv -----
// Package for the greedy wildcard matcher: beat types, codes and constants.
`default_nettype none
package gwm_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int POS_W           = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  localparam logic [7:0] STAR  = 8'h2A;
  localparam logic [7:0] QMARK = 8'h3F;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_LENGTH = 3'd0;
  localparam cfg_idx_t CFG_WORD0  = 3'd1;
  localparam cfg_idx_t CFG_WORD3  = 3'd4;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_FAILED  = 2'd1,
    ST_MATCHED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_final;
    logic       no_byte;
  } in_beat_t;

  typedef struct packed {
    logic matched;
  } out_beat_t;

  typedef struct packed {
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_beat_t;

endpackage
`default_nettype wire

// ----- src/gwm_stream_if.sv -----
// Valid/ready channel carrying one beat of a given payload type.
`default_nettype none
interface gwm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/greedy_wildcard_matcher_unit.sv -----
// Greedy wildcard matcher: streams target bytes against a configured pattern.
// The result register takes a result beat as its ending beat leaves the input register.
// Throughput: one input beat per cycle; an ending beat waits in the input register
// while the previous result beat is held, other beats keep flowing.
// The pattern step (compare, index update) sets the rate.
// Reset (synchronous, rst_n low): pattern length and bytes zero, position zero, running.
`default_nettype none
module greedy_wildcard_matcher_unit
  import gwm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire             clk,
  input  wire             rst_n,
  gwm_stream_if.sink      in_s,
  gwm_stream_if.source    out_s,
  gwm_stream_if.sink      cfg_s
);

  localparam int IDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PAT_DEPTH = 2 ** IDX_W;
  localparam pos_t MAX_POS = POS_W'(MAX_PATTERN);

  logic [7:0] pat_r [PAT_DEPTH];
  logic [7:0] pat1_a [PAT_DEPTH];
  logic [7:0] pat2_a [PAT_DEPTH];
  pos_t       len_r;

  logic       in_valid_r;
  in_beat_t   in_data_r;
  logic       out_valid_r;
  logic       matched_r;
  logic       matched_nxt;
  pos_t       pos_r, pos_nxt;
  status_t    st_r, st_nxt;

  logic       cfg_wr;
  logic       emits, out_free, adv;
  pos_t       len_eff;
  pos_t       p1, p2, tk_pos;
  logic [1:0] tk_off;
  status_t    tk_st;
  logic [IDX_W-1:0] idx;
  logic [7:0] c0, c1, c2, ct;
  logic [7:0] b;

  // configuration
  assign cfg_s.ready = 1'b1;
  assign cfg_wr      = cfg_s.valid && cfg_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_wr && cfg_s.data.index == CFG_LENGTH) begin
      len_r <= cfg_s.data.value[POS_W-1:0];
    end
  end

  for (genvar gi = 0; gi < PAT_DEPTH; gi++) begin : g_pat
    if (gi < MAX_PATTERN) begin : g_used
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          pat_r[gi] <= '0;
        end else if (cfg_wr && cfg_s.data.index == CFG_WORD0 + CFG_IDX_W'(gi / 8)) begin
          pat_r[gi] <= cfg_s.data.value[(gi % 8) * 8 +: 8];
        end
      end
    end else begin : g_unused
      always_ff @(posedge clk) begin
        pat_r[gi] <= '0;
      end
    end
    assign pat1_a[gi] = pat_r[(gi + 1) % PAT_DEPTH];
    assign pat2_a[gi] = pat_r[(gi + 2) % PAT_DEPTH];
  end

  // handshake
  assign emits      = in_data_r.no_byte || in_data_r.is_final;
  assign out_free   = !out_valid_r || out_s.ready;
  assign adv        = in_valid_r && (!emits || out_free);
  assign in_s.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_s.ready) begin
      in_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.ready && in_s.valid) begin
      in_data_r <= in_s.data;
    end
  end

  // pattern step
  always_comb begin
    len_eff = (len_r > MAX_POS) ? MAX_POS : len_r;
    p1      = pos_r + POS_W'(1);
    p2      = pos_r + POS_W'(2);
    idx     = pos_r[IDX_W-1:0];
    c0      = pat_r[idx];
    c1      = pat1_a[idx];
    c2      = pat2_a[idx];
    b       = in_data_r.text_byte;
    tk_off  = 2'd0;
    tk_st   = st_r;
    if (!in_data_r.no_byte && st_r == ST_RUNNING) begin
      priority if (pos_r >= len_eff) begin
        tk_st = ST_FAILED;
      end else if (c0 == STAR) begin
        if (p1 >= len_eff) begin
          tk_st = ST_MATCHED;
        end else if (b == c1) begin
          tk_off = 2'd2;
        end
      end else if (c0 == QMARK || c0 == b) begin
        tk_off = 2'd1;
      end else begin
        tk_st = ST_FAILED;
      end
    end
    unique case (tk_off)
      2'd1:    begin tk_pos = p1;    ct = c1; end
      2'd2:    begin tk_pos = p2;    ct = c2; end
      default: begin tk_pos = pos_r; ct = c0; end
    endcase

    priority if (tk_st == ST_MATCHED) begin
      matched_nxt = 1'b1;
    end else if (tk_st == ST_FAILED) begin
      matched_nxt = 1'b0;
    end else if (tk_pos >= len_eff) begin
      matched_nxt = 1'b1;
    end else begin
      matched_nxt = (ct == STAR) && (tk_pos + POS_W'(1) >= len_eff);
    end

    if (emits) begin
      pos_nxt = '0;
      st_nxt  = ST_RUNNING;
    end else begin
      pos_nxt = tk_pos;
      st_nxt  = tk_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      st_r  <= ST_RUNNING;
    end else if (adv) begin
      pos_r <= pos_nxt;
      st_r  <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && emits) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emits) begin
      matched_r <= matched_nxt;
    end
  end

  assign out_s.valid        = out_valid_r;
  assign out_s.data.matched = matched_r;

  // checks
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    adv && emits |=> out_valid_r)
    else $error("result beat not loaded");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    adv && emits |=> pos_r == '0 && st_r == ST_RUNNING)
    else $error("matcher did not return to pattern start");

  a_verdict_hold: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !emits && st_r != ST_RUNNING |=> $stable(pos_r) && $stable(st_r))
    else $error("state moved after verdict was known");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_data_r))
    else $error("stalled input beat lost");

endmodule
`default_nettype wire

// ----- verif/greedy_wildcard_matcher_unit_tb.sv -----
// Testbench for greedy_wildcard_matcher_unit: directed table, then predictor-checked targets.
`timescale 1ns / 100ps
module greedy_wildcard_matcher_unit_tb;
  import gwm_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int QUIET_CYCLES   = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 150;
  localparam int SQUEEZE_CYCLES = 150;
  localparam int REPORT_MAX     = 10;
  localparam cfg_idx_t CFG_WORD1 = CFG_WORD0 + 3'd1;
  localparam cfg_idx_t CFG_WORD2 = CFG_WORD0 + 3'd2;

  typedef struct packed {
    logic        is_cfg;
    cfg_idx_t    idx;
    logic [63:0] val;
    logic [7:0]  text;
    logic        fin;
    logic        nob;
    logic        pinned;
    logic        verdict;
  } stim_row_t;

  localparam int DIR_ROWS = 26;

  stim_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0, CFG_LENGTH, 64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, CFG_LENGTH, 64'd0, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0},
    '{1'b1, CFG_LENGTH, 64'd4, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, CFG_WORD0, 64'h622A613F, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h62, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h62, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h61, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b1, CFG_LENGTH, 64'd3, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, CFG_WORD0, 64'h2A2A61, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h2A, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b1, CFG_LENGTH, 64'd2, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h58, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, CFG_LENGTH, 64'd63, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, CFG_WORD3, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, CFG_WORD1, 64'h3F2A_613F_2A62_003F, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, CFG_WORD2, 64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h2A, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, CFG_LENGTH, 64'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0}
  };

  logic clk;
  logic rst_n;
  logic hold_rx;
  logic squeeze_go;
  int   send_gap_pct;
  int   recv_gap_pct;

  gwm_stream_if #(.T(in_beat_t))  in_if ();
  gwm_stream_if #(.T(out_beat_t)) out_if ();
  gwm_stream_if #(.T(cfg_beat_t)) cfg_if ();

  greedy_wildcard_matcher_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_s (out_if),
    .cfg_s (cfg_if)
  );

  // register mirror and match state
  logic [5:0]  len_reg;
  logic [63:0] word_reg [4];
  int          scan_pos;
  status_t     scan_state;
  logic        verdict_q [$];
  logic [7:0]  tgt_q [$];
  logic        want;

  int n_items;
  int n_writes;
  int n_results = 0;
  int n_errors  = 0;
  int n_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int eff_len();
    return (int'(len_reg) > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(len_reg);
  endfunction

  function automatic logic [7:0] pat_at(input int i);
    logic [4:0] k;
    k = 5'(i);
    return word_reg[k[4:3]][{k[2:0], 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] pick_alpha();
    return 8'h61 + 8'($urandom_range(3));
  endfunction

  task automatic step_matcher(input in_beat_t b, output bit emits, output logic verdict);
    int n;
    logic [7:0] c;
    n = eff_len();
    emits = 1'b0;
    verdict = 1'b0;
    if (!b.no_byte && scan_state == ST_RUNNING) begin
      if (scan_pos >= n) begin
        scan_state = ST_FAILED;
      end else begin
        c = pat_at(scan_pos);
        if (c == STAR) begin
          if (scan_pos + 1 >= n) scan_state = ST_MATCHED;
          else if (b.text_byte == pat_at(scan_pos + 1)) scan_pos += 2;
        end else if (c == QMARK || c == b.text_byte) begin
          scan_pos += 1;
        end else begin
          scan_state = ST_FAILED;
        end
      end
    end
    if (b.is_final || b.no_byte) begin
      emits = 1'b1;
      case (scan_state)
        ST_MATCHED: verdict = 1'b1;
        ST_FAILED:  verdict = 1'b0;
        default:    verdict = (scan_pos >= n) ||
                              (pat_at(scan_pos) == STAR && scan_pos + 1 >= n);
      endcase
      scan_pos = 0;
      scan_state = ST_RUNNING;
    end
  endtask

  // drop both request lines, wait out pending verdicts plus pipeline depth
  task automatic settle();
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CFG_LENGTH) len_reg = val[5:0];
    else word_reg[idx - CFG_WORD0] = val;
    n_writes++;
  endtask

  task automatic push_text(input in_beat_t b, input logic pinned, input logic pinned_val);
    bit emits;
    logic verdict;
    cfg_if.valid <= 1'b0;
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    do @(posedge clk); while (!in_if.ready);
    step_matcher(b, emits, verdict);
    if (emits) verdict_q = {verdict_q, pinned ? pinned_val : verdict};
    n_items++;
  endtask

  task automatic roll_pattern();
    logic [63:0] w [4];
    logic [5:0] n;
    int r;
    case ($urandom_range(9))
      0: n = 6'd0;
      1: n = 6'd32;
      2: n = 6'($urandom_range(63, 33));
      default: n = 6'($urandom_range(8, 1));
    endcase
    for (int k = 0; k < 32; k++) begin
      r = $urandom_range(9);
      w[k / 8][(k % 8) * 8 +: 8] = r < 3 ? STAR : r < 5 ? QMARK : r < 9 ? pick_alpha() : 8'($urandom);
    end
    write_reg(CFG_LENGTH, {58'd0, n});
    for (int k = 0; k < 4; k++) write_reg(CFG_WORD0 + cfg_idx_t'(k), w[k]);
  endtask

  // mostly targets shaped to follow the pattern, some mutated, some pure noise
  task automatic build_target();
    int n;
    int j;
    int r;
    logic [7:0] c;
    logic [7:0] nx;
    logic [7:0] x;
    tgt_q.delete();
    n = eff_len();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(6)) tgt_q = {tgt_q, 8'($urandom)};
      return;
    end
    j = 0;
    while (j < n) begin
      c = pat_at(j);
      if (c == STAR && j + 1 >= n) begin
        repeat ($urandom_range(4)) tgt_q = {tgt_q, 8'($urandom)};
        j++;
      end else if (c == STAR) begin
        nx = pat_at(j + 1);
        repeat ($urandom_range(3)) begin
          x = pick_alpha();
          tgt_q = {tgt_q, (x == nx) ? (x ^ 8'h04) : x};
        end
        tgt_q = {tgt_q, nx};
        j += 2;
      end else begin
        tgt_q = {tgt_q, (c == QMARK) ? 8'($urandom) : c};
        j++;
      end
    end
    r = $urandom_range(99);
    if (r < 10 && tgt_q.size() != 0) tgt_q[$urandom_range(tgt_q.size() - 1)] = 8'($urandom);
    else if (r < 17 && tgt_q.size() != 0) void'(tgt_q.pop_back());
    else if (r < 25) tgt_q = {tgt_q, pick_alpha()};
  endtask

  task automatic send_target();
    bit end_absent;
    in_beat_t b;
    end_absent = tgt_q.size() == 0 || $urandom_range(99) < 30;
    foreach (tgt_q[i]) begin
      b.text_byte = tgt_q[i];
      b.is_final  = !end_absent && i == tgt_q.size() - 1;
      b.no_byte   = 1'b0;
      push_text(b, 1'b0, 1'b0);
    end
    if (end_absent) begin
      b.text_byte = 8'($urandom);
      b.is_final  = 1'($urandom);
      b.no_byte   = 1'b1;
      push_text(b, 1'b0, 1'b0);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit squeeze);
    int start;
    int targets;
    send_gap_pct = send_pct;
    recv_gap_pct <= recv_pct;
    start = n_items;
    targets = 0;
    while (n_items - start < PHASE_ITEMS) begin
      if (targets % 10 == 0) begin
        roll_pattern();
        if (squeeze) squeeze_go = 1'b1;
      end
      build_target();
      send_target();
      targets++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else out_if.ready <= !hold_rx && ($urandom_range(99) >= recv_gap_pct);
  end

  // long output hold so results back up and the input stalls
  initial begin
    hold_rx <= 1'b0;
    wait (squeeze_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (SQUEEZE_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      n_results++;
      if (verdict_q.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_MAX)
          $display("unexpected result beat: matched=%0b", out_if.data.matched);
      end else begin
        want = verdict_q.pop_front();
        if (out_if.data.matched !== want) begin
          n_errors++;
          if (n_errors <= REPORT_MAX)
            $display("result %0d: matched expected %0b, got %0b",
                     n_results, want, out_if.data.matched);
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", n_cycles, verdict_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    recv_gap_pct <= 86;
    squeeze_go   = 1'b0;
    send_gap_pct = 17;
    len_reg      = '0;
    word_reg     = '{default: '0};
    scan_pos     = 0;
    scan_state   = ST_RUNNING;
    n_items      = 0;
    n_writes     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        push_text('{text_byte: dir_tab[i].text, is_final: dir_tab[i].fin,
                    no_byte: dir_tab[i].nob}, dir_tab[i].pinned, dir_tab[i].verdict);
      end
    end

    run_phase(17, 86, 1'b0);
    run_phase(86, 17, 1'b0);
    run_phase(0, 0, 1'b1);

    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d text beats, %0d register writes, %0d verdicts compared, %0d mismatches",
             n_items, n_writes, n_results, n_errors);
    $display(
      "patterns of length 0 to 63 with wildcards; idle mixes on both sides, a %0d-cycle hold",
      SQUEEZE_CYCLES);
    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- greedy_wildcard_matcher_unit.f -----
src/gwm_pkg.sv
src/gwm_stream_if.sv
src/greedy_wildcard_matcher_unit.sv
verif/greedy_wildcard_matcher_unit_tb.sv
